// ===== rtl/core/dde_pkg.sv =====
`default_nettype none

package dde_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int WEIGHT_BITS  = 16;

   localparam int VIDX_W     = $clog2(MAX_VERTICES);
   localparam int VCNT_W     = VIDX_W + 1;
   localparam int ADDR_W     = 2 * VIDX_W;
   localparam int SUM_W      = WEIGHT_BITS + 1;
   localparam int PRED_W     = VIDX_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = WEIGHT_BITS;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NO_EDGE      = CSR_IDX_W'(1);

   localparam logic [VCNT_W-1:0]      VCOUNT_RESET  = VCNT_W'(MAX_VERTICES);
   localparam logic [WEIGHT_BITS-1:0] NO_EDGE_RESET = '1;

   // Outcome of one pass of the shared add/compare unit over one matrix entry.
   typedef struct packed {
      logic                   write_dist;
      logic [WEIGHT_BITS-1:0] dist_val;
      logic                   write_link;
      logic                   link_valid;
      logic                   better;
   } relax_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/dde_ifs.sv =====
`default_nettype none

interface dde_req_if;
   import dde_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [VIDX_W-1:0]      row;
   logic [VIDX_W-1:0]      col;
   logic [WEIGHT_BITS-1:0] weight;
   logic [VIDX_W-1:0]      source;

   modport source_port (output valid, cmd, row, col, weight, source, input ready);
   modport sink_port   (input valid, cmd, row, col, weight, source, output ready);
endinterface

interface dde_rsp_if;
   import dde_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [VIDX_W-1:0]        vertex;
   logic [WEIGHT_BITS-1:0]   distance;
   logic signed [PRED_W-1:0] predecessor;
   logic                     reached;
   logic                     last;

   modport source_port (output valid, vertex, distance, predecessor, reached, last,
                        input ready);
   modport sink_port   (input valid, vertex, distance, predecessor, reached, last,
                        output ready);
endinterface

interface dde_csr_if;
   import dde_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source_port (output valid, index, data, input ready);
   modport sink_port   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dde_ram.sv =====
`default_nettype none

module dde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dde_relax_unit.sv =====
`default_nettype none

module dde_relax_unit (
   input  wire logic                            init,
   input  wire logic [dde_pkg::WEIGHT_BITS-1:0] weight,
   input  wire logic [dde_pkg::WEIGHT_BITS-1:0] base,
   input  wire logic [dde_pkg::WEIGHT_BITS-1:0] dist_cur,
   input  wire logic [dde_pkg::WEIGHT_BITS-1:0] best,
   input  wire logic [dde_pkg::WEIGHT_BITS-1:0] no_edge,
   input  wire logic                            settled,
   input  wire logic                            is_row,
   output dde_pkg::relax_result_type            result
);
   import dde_pkg::*;

   logic [SUM_W-1:0]       sum;
   logic [WEIGHT_BITS-1:0] sat;
   logic                   has_edge;
   logic                   improves;

   assign sum      = {1'b0, base} + {1'b0, weight};
   assign sat      = (sum >= {1'b0, no_edge}) ? no_edge : sum[WEIGHT_BITS-1:0];
   assign has_edge = (weight < no_edge);
   assign improves = !settled && has_edge && (sat < dist_cur);

   // During the first pass base is zero, so sat is the clipped row weight.
   always_comb begin
      result = '0;
      if (init) begin
         result.write_dist = 1'b1;
         result.dist_val   = is_row ? '0 : sat;
         result.write_link = 1'b1;
         result.link_valid = !is_row && has_edge;
      end else begin
         result.write_dist = improves;
         result.dist_val   = improves ? sat : dist_cur;
         result.write_link = improves;
         result.link_valid = 1'b1;
      end
      result.better = !settled && (result.dist_val < best);
   end

endmodule

`default_nettype wire

// ===== rtl/core/dense_dijkstra_engine.sv =====
`default_nettype none

// A load leaves the block in idle, so it stays ready for the next request.
// A run over n vertices walks n matrix rows, each with one read per cycle from the
// weight RAM followed by drain and pick; then the result beats follow, one per cycle
// while the result side is ready.
// Synchronous reset clears control, the flag vectors and the registers (32, 65535);
// the weight matrix and the distance store are not cleared and need no clearing pass.
module dense_dijkstra_engine (
   input wire logic       clock,
   input wire logic       reset,
   dde_req_if.sink_port   req_bus,
   dde_rsp_if.source_port rsp_bus,
   dde_csr_if.sink_port   csr_bus
);
   import dde_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_PICK  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [VCNT_W-1:0]        vcount_ff, vcount_in;
   logic [WEIGHT_BITS-1:0]   no_edge_ff, no_edge_in;
   logic [VIDX_W-1:0]        row_ff, row_in;
   logic [VIDX_W-1:0]        src_ff, src_in;
   logic [VIDX_W-1:0]        cnt_ff, cnt_in;
   logic [VIDX_W-1:0]        iter_ff, iter_in;
   logic                     proc_ff, proc_in;
   logic [VIDX_W-1:0]        proc_idx_ff, proc_idx_in;
   logic                     init_ff, init_in;
   logic [WEIGHT_BITS-1:0]   base_ff, base_in;
   logic [WEIGHT_BITS-1:0]   best_ff, best_in;
   logic [VIDX_W-1:0]        cand_ff, cand_in;
   logic [MAX_VERTICES-1:0]  settled_ff, settled_in;
   logic [MAX_VERTICES-1:0]  linked_ff, linked_in;
   logic [WEIGHT_BITS-1:0]   dist_ff [MAX_VERTICES];
   logic [VIDX_W-1:0]        pred_ff [MAX_VERTICES];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VIDX_W-1:0]        rsp_vertex_ff, rsp_vertex_in;
   logic [WEIGHT_BITS-1:0]   rsp_distance_ff, rsp_distance_in;
   logic signed [PRED_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic                     rsp_reached_ff, rsp_reached_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_fire;
   logic                     csr_fire;
   logic [VCNT_W-1:0]        n_use;
   logic [VCNT_W-1:0]        n_minus_one;
   logic [VIDX_W-1:0]        last_idx;
   logic                     run_ok;
   logic [VIDX_W-1:0]        rd_idx;
   logic [WEIGHT_BITS-1:0]   dist_rd;
   logic [VIDX_W-1:0]        pred_rd;
   logic                     settled_rd;
   logic                     linked_rd;
   logic [VIDX_W-1:0]        pick_vertex;
   logic [WEIGHT_BITS-1:0]   ram_rd_data;
   relax_result_type         relax;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   always_comb begin
      priority if (vcount_ff < VCNT_W'(2)) begin
         n_use = VCNT_W'(2);
      end else if (vcount_ff > VCNT_W'(MAX_VERTICES)) begin
         n_use = VCNT_W'(MAX_VERTICES);
      end else begin
         n_use = vcount_ff;
      end
   end

   assign n_minus_one = n_use - VCNT_W'(1);
   assign last_idx    = n_minus_one[VIDX_W-1:0];
   assign run_ok      = ({1'b0, req_bus.source} < n_use);

   // The vertex store has one read index: the emit counter or the entry in flight.
   assign rd_idx     = (state_ff == ST_EMIT) ? cnt_ff : proc_idx_ff;
   assign dist_rd    = dist_ff[rd_idx];
   assign pred_rd    = pred_ff[rd_idx];
   assign settled_rd = settled_ff[rd_idx];
   assign linked_rd  = linked_ff[rd_idx];

   assign pick_vertex = (best_ff < no_edge_ff) ? cand_ff : src_ff;

   dde_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (MAX_VERTICES * MAX_VERTICES)
   ) u_weights (
      .clock   (clock),
      .wr_en   (req_fire && (req_bus.cmd == CMD_LOAD)),
      .wr_addr ({req_bus.row, req_bus.col}),
      .wr_data (req_bus.weight),
      .rd_addr ({row_ff, cnt_ff}),
      .rd_data (ram_rd_data)
   );

   dde_relax_unit u_relax (
      .init     (init_ff),
      .weight   (ram_rd_data),
      .base     (base_ff),
      .dist_cur (dist_rd),
      .best     (best_ff),
      .no_edge  (no_edge_ff),
      .settled  (settled_rd),
      .is_row   (proc_idx_ff == row_ff),
      .result   (relax)
   );

   always_comb begin
      state_in        = state_ff;
      vcount_in       = vcount_ff;
      no_edge_in      = no_edge_ff;
      row_in          = row_ff;
      src_in          = src_ff;
      cnt_in          = cnt_ff;
      iter_in         = iter_ff;
      proc_in         = 1'b0;
      proc_idx_in     = cnt_ff;
      init_in         = init_ff;
      base_in         = base_ff;
      best_in         = best_ff;
      cand_in         = cand_ff;
      settled_in      = settled_ff;
      linked_in       = linked_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_vertex_in   = rsp_vertex_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_pred_in     = rsp_pred_ff;
      rsp_reached_in  = rsp_reached_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_fire) begin
         unique case (csr_bus.index)
            CSR_VERTEX_COUNT: vcount_in  = csr_bus.data[VCNT_W-1:0];
            CSR_NO_EDGE:      no_edge_in = csr_bus.data[WEIGHT_BITS-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_bus.cmd == CMD_RUN) && run_ok) begin
               settled_in                 = '0;
               settled_in[req_bus.source] = 1'b1;
               row_in                     = req_bus.source;
               src_in                     = req_bus.source;
               cnt_in                     = '0;
               iter_in                    = '0;
               init_in                    = 1'b1;
               base_in                    = '0;
               best_in                    = no_edge_ff;
               state_in                   = ST_WALK;
            end
         end
         ST_WALK: begin
            proc_in     = 1'b1;
            proc_idx_in = cnt_ff;
            if (cnt_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + VIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            init_in = 1'b0;
            cnt_in  = '0;
            if (iter_ff == last_idx) begin
               state_in = ST_EMIT;
            end else begin
               // With no reachable candidate the source is walked again, which is a no-op.
               iter_in                 = iter_ff + VIDX_W'(1);
               row_in                  = pick_vertex;
               base_in                 = (best_ff < no_edge_ff) ? best_ff : '0;
               settled_in[pick_vertex] = 1'b1;
               best_in                 = no_edge_ff;
               state_in                = ST_WALK;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_vertex_in   = cnt_ff;
               rsp_distance_in = dist_rd;
               rsp_pred_in     = linked_rd ? $signed({1'b0, pred_rd}) : '1;
               rsp_reached_in  = (cnt_ff == src_ff) || (dist_rd < no_edge_ff);
               rsp_last_in     = (cnt_ff == last_idx);
               if (cnt_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + VIDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The entry read last cycle is relaxed now; the next pick is tracked on the fly.
      if (proc_ff) begin
         if (relax.better) begin
            best_in = relax.dist_val;
            cand_in = proc_idx_ff;
         end
         if (relax.write_link) begin
            linked_in[proc_idx_ff] = relax.link_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= VCOUNT_RESET;
         no_edge_ff   <= NO_EDGE_RESET;
         proc_ff      <= 1'b0;
         settled_ff   <= '0;
         linked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         no_edge_ff   <= no_edge_in;
         proc_ff      <= proc_in;
         settled_ff   <= settled_in;
         linked_ff    <= linked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff          <= row_in;
      src_ff          <= src_in;
      cnt_ff          <= cnt_in;
      iter_ff         <= iter_in;
      proc_idx_ff     <= proc_idx_in;
      init_ff         <= init_in;
      base_ff         <= base_in;
      best_ff         <= best_in;
      cand_ff         <= cand_in;
      rsp_vertex_ff   <= rsp_vertex_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_pred_ff     <= rsp_pred_in;
      rsp_reached_ff  <= rsp_reached_in;
      rsp_last_ff     <= rsp_last_in;
      if (proc_ff && relax.write_dist) begin
         dist_ff[proc_idx_ff] <= relax.dist_val;
      end
      if (proc_ff && relax.write_link) begin
         pred_ff[proc_idx_ff] <= row_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.vertex      = rsp_vertex_ff;
   assign rsp_bus.distance    = rsp_distance_ff;
   assign rsp_bus.predecessor = rsp_pred_ff;
   assign rsp_bus.reached     = rsp_reached_ff;
   assign rsp_bus.last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_src_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> settled_ff[src_ff])
      else $error("source vertex not settled during a run");

   a_row_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> settled_ff[row_ff])
      else $error("walking the row of an unsettled vertex");

   a_proc_after_walk: assert property (@(posedge clock) disable iff (reset)
      proc_ff |-> ($past(state_ff) == ST_WALK))
      else $error("entry relaxed without a matrix read");

   a_beat_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result beat raised outside the emit phase");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import dde_pkg::*;

   localparam int STALL_LIMIT  = 6000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 1200;
   localparam int FILL_VERTICES = 5;

   localparam logic [PRED_W-1:0] NO_PRED = '1;

   typedef struct packed {
      logic [VIDX_W-1:0]      vertex;
      logic [WEIGHT_BITS-1:0] distance;
      logic [PRED_W-1:0]      predecessor;
      logic                   reached;
      logic                   last;
   } path_beat_type;

   logic clock;
   logic reset;

   dde_req_if req_bus ();
   dde_rsp_if rsp_bus ();
   dde_csr_if csr_bus ();

   dense_dijkstra_engine DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the graph and the two registers.
   logic [WEIGHT_BITS-1:0] adj [MAX_VERTICES][MAX_VERTICES];
   logic [VCNT_W-1:0]      vcount_cfg  = VCOUNT_RESET;
   logic [WEIGHT_BITS-1:0] no_edge_cfg = NO_EDGE_RESET;

   path_beat_type expected_paths [$];
   path_beat_type seen_beat;
   path_beat_type want_beat;
   int            fail_count = 0;
   bit            quiet = 1'b0;
   int unsigned   sink_hold = 0;
   int            idle_cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int vertices_used();
      int n;
      n = vcount_cfg;
      if (n < 2) n = 2;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      return n;
   endfunction

   // Array form of Dijkstra over the shadow matrix; queues one beat per vertex.
   function automatic void predict_paths(input logic [VIDX_W-1:0] src);
      int            n, i, j, k, u;
      int unsigned   inf, w, best, s;
      int unsigned   dist_est [MAX_VERTICES];
      int            pred [MAX_VERTICES];
      bit            linked [MAX_VERTICES];
      bit            settled [MAX_VERTICES];
      path_beat_type beat;
      n = vertices_used();
      inf = no_edge_cfg;
      if (src >= n) return;
      for (i = 0; i < n; i++) begin
         w = adj[src][i];
         dist_est[i] = (w >= inf) ? inf : w;
         settled[i] = 1'b0;
         linked[i] = (i != src) && (w < inf);
         pred[i] = int'(src);
      end
      settled[src] = 1'b1;
      dist_est[src] = 0;
      for (i = 0; i + 1 < n; i++) begin
         best = inf;
         u = src;
         for (j = 0; j < n; j++) begin
            if (!settled[j] && dist_est[j] < best) begin
               u = j;
               best = dist_est[j];
            end
         end
         settled[u] = 1'b1;
         for (k = 0; k < n; k++) begin
            w = adj[u][k];
            if (!settled[k] && w < inf) begin
               s = dist_est[u] + w;
               if (s >= inf) s = inf;
               if (s < dist_est[k]) begin
                  dist_est[k] = s;
                  pred[k] = u;
                  linked[k] = 1'b1;
               end
            end
         end
      end
      for (i = 0; i < n; i++) begin
         beat.vertex      = VIDX_W'(i);
         beat.distance    = WEIGHT_BITS'(dist_est[i]);
         beat.predecessor = linked[i] ? PRED_W'(pred[i]) : NO_PRED;
         beat.reached     = (i == src) || (dist_est[i] < inf);
         beat.last        = (i == n - 1);
         expected_paths.push_back(beat);
      end
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] pick_weight();
      int unsigned inf;
      inf = no_edge_cfg;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return WEIGHT_BITS'(inf);
         2: return WEIGHT_BITS'(inf - 1);
         3: return WEIGHT_BITS'($urandom_range(inf, 65535));
         4: return '1;
         default: return WEIGHT_BITS'($urandom_range(0, inf >> 3));
      endcase
   endfunction

   // Random runs stay inside the loaded corner of the matrix.
   function automatic logic [CSR_DATA_W-1:0] pick_vertex_count();
      int unsigned v;
      if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1);
      else v = $urandom_range(2, FILL_VERTICES);
      // Upper data bits are junk that the register must drop.
      return (CSR_DATA_W'($urandom) & 16'hFFC0) | CSR_DATA_W'(v);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_no_edge();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return CSR_DATA_W'($urandom_range(1, 65535));
         2: return CSR_DATA_W'($urandom_range(1, 300));
         default: return CSR_DATA_W'($urandom_range(30000, 65535));
      endcase
   endfunction

   // Drops the request valid, waits until every queued beat is seen, then lets the bus settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_paths.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_VERTEX_COUNT: vcount_cfg = data[VCNT_W-1:0];
         CSR_NO_EDGE:      no_edge_cfg = data;
         default: ;
      endcase
   endtask

   task automatic send_item(input logic cmd, input logic [VIDX_W-1:0] row,
                            input logic [VIDX_W-1:0] col,
                            input logic [WEIGHT_BITS-1:0] weight,
                            input logic [VIDX_W-1:0] source);
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= cmd;
      req_bus.row    <= row;
      req_bus.col    <= col;
      req_bus.weight <= weight;
      req_bus.source <= source;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (cmd == CMD_LOAD) adj[row][col] = weight;
      else predict_paths(source);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic load_weight(input logic [VIDX_W-1:0] row,
                              input logic [VIDX_W-1:0] col,
                              input logic [WEIGHT_BITS-1:0] weight);
      send_item(CMD_LOAD, row, col, weight, VIDX_W'($urandom));
   endtask

   task automatic run_from(input logic [VIDX_W-1:0] src);
      send_item(CMD_RUN, VIDX_W'($urandom), VIDX_W'($urandom),
                WEIGHT_BITS'($urandom), src);
   endtask

   // Runs over a few vertices read only the low corner of the matrix, so that is loaded.
   task automatic test_matrix_fill();
      int r, c;
      for (r = 0; r < FILL_VERTICES; r++)
         for (c = 0; c < FILL_VERTICES; c++)
            load_weight(VIDX_W'(r), VIDX_W'(c), pick_weight());
   endtask

   // A source without outgoing edges makes every walk of a full-size run reread its row.
   task automatic test_reset_defaults();
      int c;
      for (c = 0; c < MAX_VERTICES; c++)
         load_weight(VIDX_W'(MAX_VERTICES - 1), VIDX_W'(c), '1);
      run_from(VIDX_W'(MAX_VERTICES - 1));
   endtask

   task automatic test_weight_extremes();
      int c;
      write_reg(CSR_VERTEX_COUNT, 16'd4);
      write_reg(CSR_NO_EDGE, 16'hFFFF);
      load_weight(VIDX_W'(0), VIDX_W'(1), 16'd0);
      load_weight(VIDX_W'(0), VIDX_W'(2), 16'hFFFF);
      load_weight(VIDX_W'(0), VIDX_W'(3), 16'd60000);
      load_weight(VIDX_W'(1), VIDX_W'(2), 16'd65534);
      // Going through vertex 3 exceeds the weight range; the clipped sum must not beat 65534.
      load_weight(VIDX_W'(3), VIDX_W'(2), 16'd60000);
      run_from(VIDX_W'(0));
      // A source with no outgoing edges leaves no candidate to settle.
      for (c = 0; c < 4; c++) load_weight(VIDX_W'(2), VIDX_W'(c), 16'hFFFF);
      run_from(VIDX_W'(2));
      run_from(VIDX_W'(4));
      run_from(VIDX_W'(MAX_VERTICES - 1));
      write_reg(CSR_NO_EDGE, 16'd1000);
      load_weight(VIDX_W'(0), VIDX_W'(1), 16'd2000);
      run_from(VIDX_W'(0));
   endtask

   task automatic test_vertex_count_limits();
      write_reg(CSR_VERTEX_COUNT, 16'd0);
      run_from(VIDX_W'(1));
      write_reg(CSR_VERTEX_COUNT, 16'd1);
      run_from(VIDX_W'(0));
      run_from(VIDX_W'(2));
      write_reg(CSR_VERTEX_COUNT, 16'd2);
      run_from(VIDX_W'(1));
      write_reg(CSR_VERTEX_COUNT, 16'd63);
      run_from(VIDX_W'(MAX_VERTICES - 1));
      write_reg(CSR_VERTEX_COUNT, 16'd33);
      run_from(VIDX_W'(MAX_VERTICES - 1));
      write_reg(CSR_VERTEX_COUNT, 16'hFFC3);
      run_from(VIDX_W'(2));
   endtask

   task automatic test_no_edge_limits();
      write_reg(CSR_VERTEX_COUNT, 16'd3);
      write_reg(CSR_NO_EDGE, 16'd1);
      run_from(VIDX_W'(0));
      write_reg(CSR_NO_EDGE, 16'hFFFF);
      run_from(VIDX_W'(1));
   endtask

   task automatic test_random_traffic();
      int phase, k, n, sel;
      for (phase = 0; phase < 4; phase++) begin
         // Each phase starts from an empty pipeline, then retunes the graph size.
         if (phase == 3) quiet = 1'b1;
         write_reg(CSR_VERTEX_COUNT, pick_vertex_count());
         if ($urandom_range(0, 1) == 0) write_reg(CSR_NO_EDGE, pick_no_edge());
         n = vertices_used();
         for (k = 0; k < 5; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
               load_weight(VIDX_W'($urandom_range(0, n - 1)),
                           VIDX_W'($urandom_range(0, n - 1)), pick_weight());
            else if (sel < 6)
               // Row of the edgeless full-size source is left alone.
               load_weight(VIDX_W'($urandom_range(0, MAX_VERTICES - 2)),
                           VIDX_W'($urandom), pick_weight());
            else if (sel < 9)
               run_from(VIDX_W'($urandom_range(0, n - 1)));
            else
               run_from(VIDX_W'($urandom));
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.cmd    <= CMD_LOAD;
      req_bus.row    <= '0;
      req_bus.col    <= '0;
      req_bus.weight <= '0;
      req_bus.source <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= CSR_VERTEX_COUNT;
      csr_bus.data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_matrix_fill();
      test_reset_defaults();
      test_weight_extremes();
      test_vertex_count_limits();
      test_no_edge_limits();
      test_random_traffic();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_paths.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Result side back-pressure in short random bursts.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold != 0) begin
            sink_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(0, 7);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_beat = '{rsp_bus.vertex, rsp_bus.distance, rsp_bus.predecessor,
                       rsp_bus.reached, rsp_bus.last};
         if (expected_paths.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected beat v=%0d d=%0d p=%0d r=%0b l=%0b", $time,
                     seen_beat.vertex, seen_beat.distance,
                     $signed(seen_beat.predecessor), seen_beat.reached, seen_beat.last);
         end else begin
            want_beat = expected_paths.pop_front();
            if (seen_beat !== want_beat) begin
               fail_count++;
               $display("%0t: expected v=%0d d=%0d p=%0d r=%0b l=%0b, got v=%0d d=%0d p=%0d r=%0b l=%0b",
                        $time, want_beat.vertex, want_beat.distance,
                        $signed(want_beat.predecessor), want_beat.reached, want_beat.last,
                        seen_beat.vertex, seen_beat.distance,
                        $signed(seen_beat.predecessor), seen_beat.reached, seen_beat.last);
            end
         end
      end
   end

   // A run over 32 vertices is silent until its first result beat; the limit is well above that.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

endmodule
